/* hw/rtl/tds_linearize_and_temp_compensate_top_defines.svh */
// Assertion macros for the TDS linearisation pipeline.
`ifndef TDS_LINEARIZE_AND_TEMP_COMPENSATE_TOP_DEFINES_SVH
`define TDS_LINEARIZE_AND_TEMP_COMPENSATE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tdslc_pkg.sv */
// Constants and coefficient table for the TDS linearisation pipeline.
`default_nettype none

package tdslc_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int ADC_W        = 12;
  localparam int TEMP_W       = 13;
  localparam int TDS_W        = 23;

  // polynomial datapath
  localparam int COEF_W   = 40;
  localparam int ACC_W    = 50;   // bounds every Horner partial sum
  localparam int XE_W     = 13;   // code zero-extended to a positive signed operand
  localparam int MUL_W    = ACC_W + XE_W;
  localparam int NORM_SH  = 12;   // divide by 4096
  localparam int ALIGN_SH = 9;    // 23 to 32 fractional bits
  localparam int FRAC_SH  = 32;
  localparam int NUM_COEF = 7;

  typedef logic signed [COEF_W-1:0] coef_t;

  // d0 .. d6, 23 fractional bits
  localparam coef_t POLY_COEF [NUM_COEF] = '{
    40'sd41038441,
    40'sd1286758531,
    40'sd29543205871,
    -40'sd134506344230,
    40'sd300790892260,
    -40'sd304073583200,
    40'sd115876679768
  };

  // value widths after the polynomial
  localparam int V_W  = 18;
  localparam int F_W  = 11;
  localparam int P_W  = V_W + F_W;
  localparam int KM_W = 5;
  localparam int A_W  = 18;
  localparam int Q_W  = 12;

  localparam logic [V_W-1:0]    V_FLOOR  = V_W'(3);
  localparam logic [V_W-1:0]    V_BIG    = V_W'(7);
  localparam logic [TDS_W-1:0]  TDS_MIN  = TDS_W'(3);
  localparam logic [TDS_W-1:0]  TDS_MAX  = {TDS_W{1'b1}};

  // temperature bands
  localparam logic [TEMP_W-1:0] T_MID  = TEMP_W'(2500);
  localparam logic [TEMP_W-1:0] T_B6   = TEMP_W'(3200);
  localparam logic [TEMP_W-1:0] T_B5   = TEMP_W'(2700);
  localparam logic [TEMP_W-1:0] T_B4   = TEMP_W'(2200);
  localparam logic [TEMP_W-1:0] T_B3   = TEMP_W'(1700);
  localparam logic [TEMP_W-1:0] T_B2   = TEMP_W'(1200);
  localparam logic [TEMP_W-1:0] T_B1   = TEMP_W'(700);
  localparam logic [KM_W-1:0]   K_B6   = KM_W'(16);
  localparam logic [KM_W-1:0]   K_B5   = KM_W'(17);
  localparam logic [KM_W-1:0]   K_B4   = KM_W'(0);
  localparam logic [KM_W-1:0]   K_B3   = KM_W'(16);
  localparam logic [KM_W-1:0]   K_B2   = KM_W'(24);
  localparam logic [KM_W-1:0]   K_B1   = KM_W'(26);
  localparam logic [KM_W-1:0]   K_B0   = KM_W'(28);
  localparam logic [Q_W-1:0]    F_BASE = Q_W'(1000);

  // reciprocal for /100 on magnitudes below 2^A_W
  localparam int DIV100_D = 100;
  localparam int DIV100_S = 26;
  localparam int DIV100_W = 20;
  localparam logic [DIV100_W-1:0] DIV100_M =
    DIV100_W'(((64'd1 << DIV100_S) + 64'(DIV100_D) - 64'd1) / 64'(DIV100_D));

  // net scale: (v*8/7)/1000 folds to v/875
  localparam int NET_D = 875;
  localparam int NET_S = 40;
  localparam int NET_W = 31;
  localparam logic [NET_W-1:0] NET_M =
    NET_W'(((64'd1 << NET_S) + 64'(NET_D) - 64'd1) / 64'(NET_D));
  localparam int NQ_W = P_W + NET_W - NET_S;

  localparam int NUM_STG = 10;

endpackage

`default_nettype wire

/* hw/rtl/tds_linearize_and_temp_compensate_top.sv */
// TDS probe linearisation and temperature compensation pipeline.
//
//  channel   dir  tdata fields (low bit up)                         tuser
//  s_axis    in   adc_code[11:0] water_temp[24:12] update_enable[25] is_net_channel
//  m_axis    out  tds_value[22:0]                                   from_net_channel
//
// One item per cycle while m_axis_tready is high; m_axis_tvalid is the last stage's valid bit.
// Ten register stages: input capture, six Horner steps (one 50x13 multiply and add
// each), small-value steps, temperature multiply, net scale and clamp.
// Reset clears only the stage valid bits. A disabled item is taken and dropped.
// A full stage holds while the next one stalls; ready ripples back from m_axis_tready,
// so bubbles close up and a stalled output still lets earlier stages fill.
`default_nettype none
`include "tds_linearize_and_temp_compensate_top_defines.svh"

module tds_linearize_and_temp_compensate_top #(
  parameter int ADC_BITS = tdslc_pkg::ADC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // adc_code, water_temp, update_enable
  input  wire logic        s_axis_tuser,   // is_net_channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // tds_value, zero pad
  output logic             m_axis_tuser    // from_net_channel
);
  import tdslc_pkg::*;

  logic [NUM_STG-1:0] valid_q;
  logic [NUM_STG-1:0] en;

  // stage payloads
  logic [ADC_BITS-1:0]     x_q   [0:5];
  logic signed [ACC_W-1:0] acc_q [1:6];
  logic [F_W-1:0]          f_q   [1:7];
  logic                    net_q [0:9];
  logic [A_W-1:0]          a_q;
  logic                    dpos_q;
  logic [V_W-1:0]          v_q;
  logic                    big_q;
  logic [P_W-1:0]          p_q;
  logic [TDS_W-1:0]        tds_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    en[NUM_STG-1] = !valid_q[NUM_STG-1] || m_axis_tready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid && s_axis_tdata[25];
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic [TEMP_W-1:0] t_in;
  logic [TEMP_W-1:0] dmag;
  logic [KM_W-1:0]   kmag;
  logic [A_W-1:0]    a_d;

  assign t_in = s_axis_tdata[24:12];

  always_comb begin
    if (t_in > T_B6)      kmag = K_B6;
    else if (t_in > T_B5) kmag = K_B5;
    else if (t_in > T_B4) kmag = K_B4;
    else if (t_in > T_B3) kmag = K_B3;
    else if (t_in > T_B2) kmag = K_B2;
    else if (t_in > T_B1) kmag = K_B1;
    else                  kmag = K_B0;
    dmag = (t_in > T_MID) ? (t_in - T_MID) : (T_MID - t_in);
    a_d  = A_W'(dmag) * A_W'(kmag);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[0]   <= s_axis_tdata[ADC_BITS-1:0];
      net_q[0] <= s_axis_tuser;
      a_q      <= a_d;
      dpos_q   <= t_in > T_MID;
    end
  end

  // ---------------------------------------------------------------- stage 1 factor
  logic [A_W+DIV100_W-1:0] prod100;
  logic [Q_W-1:0]          q100;
  logic [F_W-1:0]          f_d;

  // k is never positive, so the product has the opposite sign of T-2500
  always_comb begin
    prod100 = (A_W+DIV100_W)'(a_q) * (A_W+DIV100_W)'(DIV100_M);
    q100    = Q_W'(prod100 >> DIV100_S);
    f_d     = dpos_q ? F_W'(F_BASE - q100) : F_W'(F_BASE + q100);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      f_q[1] <= f_d;
    end
  end

  // ---------------------------------------------------------------- Horner stages 1..6
  logic signed [ACC_W-1:0] acc_in [1:6];
  logic signed [ACC_W-1:0] acc_d  [1:6];

  for (genvar h = 1; h <= 6; h++) begin : g_horner
    logic signed [MUL_W-1:0] prod;
    logic signed [MUL_W-1:0] prod_sh;
    logic signed [ACC_W-1:0] coef_al;

    if (h == 1) begin : g_first
      assign acc_in[h] = ACC_W'(POLY_COEF[NUM_COEF-1]) <<< ALIGN_SH;
    end else begin : g_next
      assign acc_in[h] = acc_q[h-1];
    end

    // arithmetic shift gives the floor of the division by 4096
    always_comb begin
      coef_al  = ACC_W'(POLY_COEF[NUM_COEF-1-h]) <<< ALIGN_SH;
      prod     = MUL_W'(acc_in[h]) * $signed(XE_W'(x_q[h-1]));
      prod_sh  = prod >>> NORM_SH;
      acc_d[h] = ACC_W'(prod_sh) + coef_al;
    end

    always_ff @(posedge clk_i) begin
      if (en[h]) begin
        acc_q[h] <= acc_d[h];
      end
    end
  end

  for (genvar k = 1; k <= 5; k++) begin : g_xcarry
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        x_q[k] <= x_q[k-1];
      end
    end
  end

  for (genvar k = 2; k <= 7; k++) begin : g_fcarry
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        f_q[k] <= f_q[k-1];
      end
    end
  end

  for (genvar k = 1; k <= 9; k++) begin : g_ncarry
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        net_q[k] <= net_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic [ACC_W-1:0] mag;
  logic [V_W-1:0]   vr;
  logic [V_W-1:0]   vs;

  always_comb begin
    mag = (acc_q[6] < 0) ? ACC_W'(-acc_q[6]) : ACC_W'(acc_q[6]);
    vr  = V_W'(mag >> FRAC_SH);
    // small-value steps merged with the floor of 3
    if (vr < V_W'(7))       vs = V_FLOOR;
    else if (vr == V_W'(7)) vs = V_W'(4);
    else if (vr < V_W'(11)) vs = vr - V_W'(2);
    else                    vs = vr;
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      v_q   <= vs;
      big_q <= vs > V_BIG;
    end
  end

  // ---------------------------------------------------------------- stage 8
  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      p_q <= big_q ? (P_W'(v_q) * P_W'(f_q[7])) : P_W'(v_q);
    end
  end

  // ---------------------------------------------------------------- stage 9
  logic [P_W+NET_W-1:0] prodn;
  logic [NQ_W-1:0]      qn;
  logic [TDS_W-1:0]     out_d;

  always_comb begin
    prodn = (P_W+NET_W)'(p_q) * (P_W+NET_W)'(NET_M);
    qn    = NQ_W'(prodn >> NET_S);
    if (net_q[8]) begin
      if (qn > NQ_W'(TDS_MAX))      out_d = TDS_MAX;
      else if (qn < NQ_W'(TDS_MIN)) out_d = TDS_MIN;
      else                          out_d = TDS_W'(qn);
    end else begin
      if (p_q > P_W'(TDS_MAX))      out_d = TDS_MAX;
      else if (p_q < P_W'(TDS_MIN)) out_d = TDS_MIN;
      else                          out_d = TDS_W'(p_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      tds_q <= out_d;
    end
  end

  assign m_axis_tvalid = valid_q[NUM_STG-1];
  assign m_axis_tdata  = {1'b0, tds_q};
  assign m_axis_tuser  = net_q[9];

  // ---------------------------------------------------------------- checks
  logic drop_xfer;
  logic full_stall;

  assign drop_xfer  = s_axis_tvalid && s_axis_tready && !s_axis_tdata[25];
  assign full_stall = (&valid_q) && !m_axis_tready;

  `TDS_ASSERT_NXT(a_disabled_dropped, drop_xfer, !valid_q[0], "disabled item entered")
  `TDS_ASSERT_IMP(a_full_stall_blocks, full_stall, !s_axis_tready, "ready while stalled")
  `TDS_ASSERT_IMP(a_out_floor, m_axis_tvalid, tds_q >= TDS_MIN, "result below floor")

endmodule

`default_nettype wire
